FILE: src/utp_pkg.sv
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types and constants of the unsigned integer text parser.
// ----------------------------------------------------------------------------
package utp_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int MID_DEPTH       = 2;
    localparam int OUT_DEPTH       = 2;

    localparam int        BASE_WIDTH = 6;
    localparam logic [5:0] BASE_RESET = 6'd10;
    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_ONE   = 6'd1;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_MAX   = 6'd36;

    // digit code of a byte that is no alphanumeric character
    localparam logic [5:0] DIGIT_NONE = 6'h3f;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UF    = 8'd70;
    localparam logic [7:0] CH_UX    = 8'd88;
    localparam logic [7:0] CH_UZ    = 8'd90;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LF    = 8'd102;
    localparam logic [7:0] CH_LX    = 8'd120;
    localparam logic [7:0] CH_LZ    = 8'd122;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BASE = 2'd1,
        ST_NO_DIGIT = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_LEAD   = 6'b000010,
        PH_START  = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_XSEEN  = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    // classified character as handed from front to back
    typedef struct packed {
        logic       first;
        logic       space;
        logic       plus;
        logic       minus;
        logic       zero;
        logic       x_ch;
        logic       hex;
        logic [5:0] digit;
    } t_class;

    localparam int CLASS_WIDTH = $bits(t_class);

endpackage

FILE: src/unsigned_integer_text_parser_top.sv
// ----------------------------------------------------------------------------
// unsigned_integer_text_parser_top
// Streaming text-to-unsigned converter with queue-style ports.
// ----------------------------------------------------------------------------
// One character word is pushed per cycle while full is low; a word with
// i_first_char set opens a new string and drops any parse in progress.
// Leading whitespace and one sign are skipped, then digits of the base in the
// number_base register (2..36, or 0 to pick 16/8/10 from a "0x"/"0" prefix)
// are accumulated. The first byte that is not a digit, or NUL, closes the
// string and queues one result word: value (negated modulo 2^VALUE_WIDTH
// after '-', all ones on overflow), end_offset (bytes consumed) and status
// (ok, bad base, no digits, overflow). A bad base gives its result on the
// first byte. Throughput is one character per cycle, with a combinational
// multiply-accumulate in the back end; the parser stalls only while the
// result queue is full. A result word is on the output from the cycle after
// the edge that hands its closing byte to the parser.
// Bytes pushed outside a string are dropped. number_base is sampled when a
// string opens and must only be written while no result is outstanding.
// ----------------------------------------------------------------------------
module unsigned_integer_text_parser_top #(
    parameter int VALUE_WIDTH = utp_pkg::DEF_VALUE_WIDTH,
    parameter int COUNT_WIDTH = utp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config
    input  logic                   i_cfg_wr_en,
    input  logic [5:0]             i_cfg_wr_data,
    // character side
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_character,
    input  logic                   i_first_char,
    // result side
    output logic                   empty,
    input  logic                   pop,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [COUNT_WIDTH-1:0] o_end_offset,
    output logic [1:0]             o_status
);
    import utp_pkg::*;

    localparam int RES_WIDTH = VALUE_WIDTH + COUNT_WIDTH + 2;

    logic [5:0]             r_number_base;

    // front to back
    t_class                 mid_word;
    logic                   mid_empty;
    logic                   mid_pop;

    // back to result queue
    logic                   res_push;
    logic                   res_full;
    logic [VALUE_WIDTH-1:0] res_value;
    logic [COUNT_WIDTH-1:0] res_end;
    logic [1:0]             res_status;
    logic [RES_WIDTH-1:0]   res_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    // classify and queue characters
    utp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_character  (i_character),
        .i_first_char (i_first_char),
        .o_word       (mid_word),
        .o_empty      (mid_empty),
        .i_pop        (mid_pop)
    );

    // parse; stalls only while the result queue is full
    utp_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number_base (r_number_base),
        .i_word        (mid_word),
        .i_empty       (mid_empty),
        .o_pop         (mid_pop),
        .i_full        (res_full),
        .o_push        (res_push),
        .o_value       (res_value),
        .o_end_offset  (res_end),
        .o_status      (res_status)
    );

    // result queue decouples the parser from the consumer
    utp_fifo #(
        .WIDTH (RES_WIDTH),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_value, res_end, res_status}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_value      = res_q[RES_WIDTH-1 -: VALUE_WIDTH];
    assign o_end_offset = res_q[COUNT_WIDTH+1 -: COUNT_WIDTH];
    assign o_status     = res_q[1:0];

endmodule

FILE: src/utp_fifo.sv
// ----------------------------------------------------------------------------
// utp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module utp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (wr && !rd) begin
            n_count = r_count + CNTW'(1);
        end else if (rd && !wr) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: src/utp_front.sv
// ----------------------------------------------------------------------------
// utp_front
// Accepts characters, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module utp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_character,
    input  logic            i_first_char,
    output utp_pkg::t_class o_word,
    output logic            o_empty,
    input  logic            i_pop
);
    import utp_pkg::*;

    t_class                 cls;
    logic [CLASS_WIDTH-1:0] q_data;

    always_comb begin
        cls       = '0;
        cls.first = i_first_char;
        cls.space = ((i_character >= CH_TAB) && (i_character <= CH_CR))
                    || (i_character == CH_SPACE);
        cls.plus  = (i_character == CH_PLUS);
        cls.minus = (i_character == CH_MINUS);
        cls.zero  = (i_character == CH_0);
        cls.x_ch  = (i_character == CH_LX) || (i_character == CH_UX);
        cls.hex   = ((i_character >= CH_0) && (i_character <= CH_9))
                    || ((i_character >= CH_LA) && (i_character <= CH_LF))
                    || ((i_character >= CH_UA) && (i_character <= CH_UF));
        if ((i_character >= CH_0) && (i_character <= CH_9)) begin
            cls.digit = 6'(i_character - CH_0);
        end else if ((i_character >= CH_LA) && (i_character <= CH_LZ)) begin
            cls.digit = 6'(i_character - CH_LA + 8'd10);
        end else if ((i_character >= CH_UA) && (i_character <= CH_UZ)) begin
            cls.digit = 6'(i_character - CH_UA + 8'd10);
        end else begin
            cls.digit = DIGIT_NONE;
        end
    end

    utp_fifo #(
        .WIDTH (CLASS_WIDTH),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_empty (o_empty)
    );

    assign o_word = t_class'(q_data);

endmodule

FILE: src/utp_back.sv
// ----------------------------------------------------------------------------
// utp_back
// Parse state machine and digit multiply-accumulate; emits one result word.
// ----------------------------------------------------------------------------
module utp_back #(
    parameter int VALUE_WIDTH = utp_pkg::DEF_VALUE_WIDTH,
    parameter int COUNT_WIDTH = utp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [5:0]             i_number_base,
    input  utp_pkg::t_class        i_word,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [COUNT_WIDTH-1:0] o_end_offset,
    output logic [1:0]             o_status
);
    import utp_pkg::*;

    localparam int SW = VALUE_WIDTH + BASE_WIDTH;

    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_minus, n_minus;
    logic                   r_ovf, n_ovf;
    logic [5:0]             r_base, n_base;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                   go;
    logic                   hit;
    logic                   do_start, do_digit, any;
    logic [SW-1:0]          mac;
    t_status                st;

    assign go    = !i_empty && !i_full;
    assign o_pop = go;

    // a result only leaves with a word that is actually taken
    assign o_push = go && hit;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_minus  = r_minus;
        n_ovf    = r_ovf;
        n_base   = r_base;
        n_count  = r_count;
        do_start = 1'b0;
        do_digit = 1'b0;
        any      = 1'b0;
        hit      = 1'b0;
        o_value  = '0;
        o_end_offset = '0;
        st       = ST_OK;

        if (i_word.first) begin
            n_acc   = '0;
            n_minus = 1'b0;
            n_ovf   = 1'b0;
            n_count = '0;
            n_base  = i_number_base;
            n_phase = PH_LEAD;
        end

        // accumulator is zero whenever the base is still being settled
        mac = SW'(n_acc) * SW'(n_base) + SW'(i_word.digit);

        if (i_word.first && ((i_number_base == BASE_ONE) || (i_number_base > BASE_MAX))) begin
            n_base  = BASE_AUTO;
            n_phase = PH_IDLE;
            hit     = 1'b1;
            st      = ST_BAD_BASE;
        end else begin
            case (n_phase)
                PH_LEAD: begin
                    if (i_word.space) begin
                        if (!(&n_count)) n_count = n_count + COUNT_WIDTH'(1);
                    end else if (i_word.plus || i_word.minus) begin
                        n_minus = i_word.minus;
                        if (!(&n_count)) n_count = n_count + COUNT_WIDTH'(1);
                        n_phase = PH_START;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                PH_START: begin
                    do_start = 1'b1;
                end
                PH_ZERO: begin
                    if (i_word.x_ch) begin
                        if (!(&n_count)) n_count = n_count + COUNT_WIDTH'(1);
                        n_phase = PH_XSEEN;
                    end else begin
                        do_digit = 1'b1;
                        any      = 1'b1;
                    end
                end
                PH_XSEEN: begin
                    if (i_word.hex) begin
                        n_base   = BASE_HEX;
                        do_digit = 1'b1;
                        any      = 1'b1;
                    end else begin
                        // "0x" without hex digit: value 0, ends after the '0'
                        hit          = 1'b1;
                        o_end_offset = n_count - COUNT_WIDTH'(1);
                        n_phase      = PH_IDLE;
                    end
                end
                PH_DIGITS: begin
                    do_digit = 1'b1;
                    any      = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_start) begin
                if (((n_base == BASE_AUTO) || (n_base == BASE_HEX)) && i_word.zero) begin
                    if (n_base == BASE_AUTO) n_base = BASE_OCT;
                    if (!(&n_count)) n_count = n_count + COUNT_WIDTH'(1);
                    n_phase = PH_ZERO;
                end else begin
                    if (n_base == BASE_AUTO) n_base = BASE_DEC;
                    do_digit = 1'b1;
                end
            end

            if (do_digit) begin
                if (i_word.digit < n_base) begin
                    n_acc = mac[VALUE_WIDTH-1:0];
                    if (|mac[SW-1:VALUE_WIDTH]) n_ovf = 1'b1;
                    if (!(&n_count)) n_count = n_count + COUNT_WIDTH'(1);
                    n_phase = PH_DIGITS;
                end else begin
                    hit     = 1'b1;
                    n_phase = PH_IDLE;
                    if (!any) begin
                        st = ST_NO_DIGIT;
                    end else if (n_ovf) begin
                        st           = ST_OVERFLOW;
                        o_value      = '1;
                        o_end_offset = n_count;
                    end else begin
                        o_value      = n_minus ? (VALUE_WIDTH'(0) - n_acc) : n_acc;
                        o_end_offset = n_count;
                    end
                end
            end
        end
    end

    assign o_status = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_ovf   <= 1'b0;
            r_base  <= BASE_AUTO;
            r_count <= '0;
        end else if (go) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_ovf   <= n_ovf;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

endmodule

FILE: src/utp_checker.sv
// ----------------------------------------------------------------------------
// utp_checker
// Port-level checks of the text parser, bound to the top level.
// ----------------------------------------------------------------------------
module utp_checker #(
    parameter int VALUE_WIDTH = utp_pkg::DEF_VALUE_WIDTH,
    parameter int COUNT_WIDTH = utp_pkg::DEF_COUNT_WIDTH
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [VALUE_WIDTH-1:0] o_value,
    input logic [COUNT_WIDTH-1:0] o_end_offset,
    input logic [1:0]             o_status
);
    import utp_pkg::*;

    // both queues come out of reset drained
    a_reset_drained: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not drained after reset");

    // a waiting result word holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_value) && $stable(o_end_offset)
                           && $stable(o_status))
        else $error("result word changed while waiting");

    // bad base and no digits report zero value and zero offset
    a_no_conv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_status == ST_BAD_BASE || o_status == ST_NO_DIGIT)
            |-> o_value == '0 && o_end_offset == '0)
        else $error("no-conversion result carries nonzero fields");

    // overflow saturates to all ones
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ST_OVERFLOW |-> &o_value)
        else $error("overflow result not saturated");

endmodule

bind unsigned_integer_text_parser_top utp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_utp_checker (.*);

FILE: bench/tb_unsigned_integer_text_parser_top.sv
// ----------------------------------------------------------------------------
// tb_unsigned_integer_text_parser_top
// Self-checking bench for the streaming text-to-unsigned parser.
// ----------------------------------------------------------------------------
// Character words are pushed with random gaps. An in-bench parser keeps the
// same per-string state as the block and queues the result word that each
// closing byte should produce. Result words are popped with random stalls and
// compared field by field in order. Directed strings cover the base corners,
// prefixes, signs, overflow, empty and abandoned strings. Random strings then
// run through a series of number_base values.
// ----------------------------------------------------------------------------
module tb_unsigned_integer_text_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utp_pkg::*;

    localparam int VALUE_W      = DEF_VALUE_WIDTH;
    localparam int COUNT_W      = DEF_COUNT_WIDTH;
    localparam int GAP_MAX      = 14;     // longest idle stretch on either side
    localparam int DRAIN_CYCLES = 8;      // margin for words that close no string
    localparam int STALL_LIMIT  = 1000;   // cycles with no word moving at all
    localparam int RANDOM_CHARS = 1400;
    localparam int REPORT_CAP   = 100;

    localparam logic [7:0] CH_NUL = 8'd0;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] end_offset;
        t_status            status;
    } t_parse_word;

    typedef logic [7:0] t_text[$];

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [5:0]         i_cfg_wr_data = BASE_RESET;
    logic               push          = 1'b0;
    logic               full;
    logic [7:0]         i_character   = CH_NUL;
    logic               i_first_char  = 1'b0;
    logic               empty;
    logic               pop           = 1'b0;
    logic [VALUE_W-1:0] o_value;
    logic [COUNT_W-1:0] o_end_offset;
    logic [1:0]         o_status;

    unsigned_integer_text_parser_top #(
        .VALUE_WIDTH (VALUE_W),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_character   (i_character),
        .i_first_char  (i_first_char),
        .empty         (empty),
        .pop           (pop),
        .o_value       (o_value),
        .o_end_offset  (o_end_offset),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench-side parser state (mirrors the block after reset)
    // ------------------------------------------------------------------------
    logic [5:0]         base_reg   = BASE_RESET;  // number_base register
    t_phase             cur_phase  = PH_IDLE;
    logic [VALUE_W-1:0] acc_value  = '0;
    bit                 neg_flag   = 1'b0;
    bit                 ovf_flag   = 1'b0;
    logic [5:0]         str_base   = '0;          // base latched at string open
    logic [COUNT_W-1:0] byte_count = '0;

    t_parse_word expected_words[$];
    int          mismatches   = 0;
    int          chars_sent   = 0;
    int          stall_cycles = 0;
    bit          src_idle     = 1'b1;  // sender inserts random gaps
    bit          snk_idle     = 1'b1;  // receiver inserts random stalls

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic bit is_hexdigit(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return 6'(c - CH_0);
        if (c >= CH_LA && c <= CH_LZ) return 6'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UZ) return 6'(c - CH_UA + 8'd10);
        return DIGIT_NONE;
    endfunction

    // acc = acc * base + d, wrapping; anything past the top sets the flag
    function automatic void mac_digit(input logic [5:0] d);
        logic [VALUE_W+6:0] wide;
        wide = (VALUE_W+7)'(acc_value) * str_base + d;
        if (wide[VALUE_W+6:VALUE_W] != '0) ovf_flag = 1'b1;
        acc_value = wide[VALUE_W-1:0];
    endfunction

    function automatic void count_byte();
        if (byte_count != '1) byte_count = byte_count + 1'b1;
    endfunction

    function automatic bit close_string(input logic [VALUE_W-1:0] v,
                                        input logic [COUNT_W-1:0] off,
                                        input t_status st, output t_parse_word w);
        w.value      = v;
        w.end_offset = off;
        w.status     = st;
        cur_phase    = PH_IDLE;
        return 1'b1;
    endfunction

    function automatic bit take_digit(input logic [7:0] c, input bit seen,
                                      output t_parse_word w);
        logic [5:0] d;
        d = digit_value(c);
        if (c != CH_NUL && d < str_base) begin
            mac_digit(d);
            count_byte();
            cur_phase = PH_DIGITS;
            return 1'b0;
        end
        if (!seen) return close_string('0, '0, ST_NO_DIGIT, w);
        // overflow reports all ones regardless of sign
        if (ovf_flag) return close_string('1, byte_count, ST_OVERFLOW, w);
        return close_string(neg_flag ? -acc_value : acc_value, byte_count, ST_OK, w);
    endfunction

    // first byte after blanks/sign: a '0' may open an octal or 0x prefix
    function automatic bit open_number(input logic [7:0] c, output t_parse_word w);
        if ((str_base == BASE_AUTO || str_base == BASE_HEX) && c == CH_0) begin
            if (str_base == BASE_AUTO) str_base = BASE_OCT;
            count_byte();  // accumulator is still zero, nothing to add
            cur_phase = PH_ZERO;
            return 1'b0;
        end
        if (str_base == BASE_AUTO) str_base = BASE_DEC;
        return take_digit(c, 1'b0, w);
    endfunction

    // Advance the bench parser by one accepted character word; returns 1 when
    // the word closes a string, with the result word it should produce.
    function automatic bit predict_parse(input logic [7:0] c, input bit first,
                                         output t_parse_word w);
        if (first) begin
            acc_value  = '0;
            neg_flag   = 1'b0;
            ovf_flag   = 1'b0;
            byte_count = '0;
            str_base   = base_reg;
            if (str_base == BASE_ONE || str_base > BASE_MAX) begin
                str_base = BASE_AUTO;
                return close_string('0, '0, ST_BAD_BASE, w);
            end
            cur_phase = PH_LEAD;
        end
        case (cur_phase)
            PH_LEAD: begin
                if (is_blank(c)) begin
                    count_byte();
                    return 1'b0;
                end
                if (c == CH_MINUS || c == CH_PLUS) begin
                    neg_flag = (c == CH_MINUS);
                    count_byte();
                    cur_phase = PH_START;
                    return 1'b0;
                end
                return open_number(c, w);
            end
            PH_START: return open_number(c, w);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    count_byte();
                    cur_phase = PH_XSEEN;
                    return 1'b0;
                end
                return take_digit(c, 1'b1, w);
            end
            PH_XSEEN: begin
                if (is_hexdigit(c)) begin
                    str_base = BASE_HEX;
                    return take_digit(c, 1'b1, w);
                end
                // bare "0x": only the '0' counts as consumed
                return close_string('0, byte_count - 1'b1, ST_OK, w);
            end
            PH_DIGITS: return take_digit(c, 1'b1, w);
            default: return 1'b0;  // idle: stray byte is dropped
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Character side. Called right after a rising edge. push stays high when
    // the next word follows with no gap, so it is never lowered and raised in
    // the same step.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input bit first);
        t_parse_word w;
        int          gap;
        push         <= 1'b1;
        i_character  <= c;
        i_first_char <= first;
        do @(posedge i_clk); while (full !== 1'b0);
        chars_sent++;
        if (predict_parse(c, first, w)) expected_words.push_back(w);
        gap = src_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(input t_text text);
        foreach (text[i]) send_char(text[i], i == 0);
    endtask

    function automatic t_text to_text(input string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    task automatic send_text(input string s, input logic [7:0] stop);
        t_text t;
        t = to_text(s);
        t.push_back(stop);
        send_bytes(t);
    endtask

    // Stop pushing, wait for every queued result word, then give the pipe
    // time to finish words that close nothing.
    task automatic quiesce();
        push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [5:0] b);
        quiesce();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= b;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        base_reg = b;
    endtask

    function automatic logic [7:0] blank_char();
        logic [7:0] c;
        c = 8'($urandom_range(CH_TAB, CH_CR + 1));
        return (c > CH_CR) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] digit_char(input int radix);
        int d;
        d = $urandom_range(0, radix - 1);
        if (d < 10) return 8'(CH_0 + d);
        return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    function automatic logic [5:0] pick_base();
        case ($urandom_range(0, 9))
            0: return BASE_AUTO;
            1: return 6'd2;
            2: return BASE_MAX;
            3: return BASE_HEX;
            4: return BASE_OCT;
            5: return BASE_DEC;
            6: return $urandom_range(0, 1) ? BASE_ONE : 6'($urandom_range(37, 63));
            default: return 6'($urandom_range(2, 36));
        endcase
    endfunction

    // Well-formed number text for the current base: blanks, optional sign,
    // optional prefix, digits, then a byte that ends it. With cut set the
    // tail is chopped off so the next string abandons this one.
    task automatic send_random_number(input bit cut);
        t_text      text;
        int         radix;
        logic [7:0] c;
        radix = (base_reg == BASE_ONE || base_reg > BASE_MAX) ? 10 : int'(base_reg);
        repeat ($urandom_range(0, 3)) text.push_back(blank_char());
        case ($urandom_range(0, 3))
            0: text.push_back(CH_MINUS);
            1: text.push_back(CH_PLUS);
            default: ;
        endcase
        if ((radix == BASE_AUTO || radix == BASE_HEX) && $urandom_range(0, 1)) begin
            text.push_back(CH_0);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            radix = BASE_HEX;
        end else if (radix == BASE_AUTO) begin
            radix = $urandom_range(0, 1) ? BASE_OCT : BASE_DEC;
            if (radix == BASE_OCT) text.push_back(CH_0);
        end
        // mostly short numbers; some long enough to overflow in any base
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 10))
            text.push_back(digit_char(radix));
        c = 8'($urandom_range(0, 255));
        if (c != CH_NUL && digit_value(c) < radix) c = CH_NUL;
        text.push_back(c);
        if (cut) repeat ($urandom_range(1, text.size())) void'(text.pop_back());
        send_bytes(text);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // base 10 straight out of reset, no register write yet
    task automatic test_decimal_reset_base();
        send_text("0", CH_NUL);
        send_text("4294967295", CH_NUL);
        send_text("4294967296", CH_NUL);      // one past the top
        send_text("-99999999999", CH_SPACE);  // overflow wins over the sign
        send_text("-1", CH_NUL);              // wraps to all ones, status ok
        send_text("+42", CH_SPACE);
        send_text(" \t\n-7", CH_LX);
        send_text("", CH_NUL);                // NUL opens and closes: no digits
        send_text("-", CH_NUL);               // lone sign
        send_text("  +", "q");
        send_text("abc", CH_NUL);
        send_char(CH_9, 1'b0);                // outside any string: dropped
        send_bytes(to_text("12"));            // abandoned by the next open
        send_text("34", CH_NUL);
    endtask

    task automatic test_auto_base();
        write_base(BASE_AUTO);
        send_text("0x1f", CH_NUL);
        send_text("0XFF", CH_SPACE);
        send_text("0x", "g");                 // prefix with no hex digit
        send_text("0x", CH_NUL);
        send_text("017", CH_NUL);             // octal
        send_text("08", CH_NUL);              // '8' ends an octal number
        send_text("0", CH_NUL);
        send_text("123", CH_NUL);
        send_text("-0x10", CH_NUL);
        send_text("  +0x7fffffff", "z");
        send_text("0x100000000", CH_NUL);
    endtask

    // bad base: result on the opening byte, rest of the string ignored
    task automatic test_invalid_base();
        write_base(BASE_ONE);
        send_text("123", CH_NUL);
        write_base(BASE_MAX + 6'd1);
        send_text("7", CH_SPACE);
        write_base(6'h3f);
        send_text("", CH_NUL);
    endtask

    task automatic test_extreme_bases();
        t_text ones;
        write_base(6'd2);
        repeat (32) ones.push_back("1");
        ones.push_back(CH_NUL);
        send_bytes(ones);                     // all ones, exactly fits
        void'(ones.pop_back());
        ones.push_back("1");
        ones.push_back(CH_NUL);
        send_bytes(ones);                     // one bit too many
        send_text("-101", "2");
        write_base(BASE_MAX);
        send_text("zik0zj", CH_NUL);          // 2^31-1 in base 36
        send_text("ZIK0ZK", CH_NUL);
        send_text("Zz", "!");
        write_base(BASE_HEX);
        send_text("0x10", CH_NUL);
        send_text("ffffffff", CH_NUL);
        send_text("0xG", CH_NUL);
        send_text("0X", CH_NUL);
    endtask

    task automatic test_random_strings();
        int start;
        int roll;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            write_base(pick_base());
            // some phases run one or both sides flat out
            src_idle = $urandom_range(0, 3) != 0;
            snk_idle = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(10, 25)) begin
                roll = $urandom_range(0, 9);
                if (roll < 7) send_random_number(1'b0);
                else if (roll < 9) send_random_number(1'b1);
                else send_noise();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall after each popped word
    // ------------------------------------------------------------------------
    initial begin : result_pop
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                stall = snk_idle ? $urandom_range(0, GAP_MAX) : 0;
                if (stall > 0) begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    // compare each popped word with the oldest expected one
    always @(posedge i_clk) begin : check_words
        t_parse_word w;
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("result word with none expected: value %0h end_offset %0d status %0d",
                           o_value, o_end_offset, o_status);
            end else begin
                w = expected_words.pop_front();
                if (o_value !== w.value) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("value: expected %0h, got %0h", w.value, o_value);
                end
                if (o_end_offset !== w.end_offset) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("end_offset: expected %0d, got %0d", w.end_offset, o_end_offset);
                end
                if (o_status !== w.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("status: expected %0d, got %0d", w.status, o_status);
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_decimal_reset_base();
        test_auto_base();
        test_invalid_base();
        test_extreme_bases();
        test_random_strings();
        snk_idle = 1'b0;
        quiesce();
        // extra room to catch stray words after the last expected one
        repeat (2 * GAP_MAX) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
